### hdl/ebac_pkg.sv
package ebac_pkg;

    typedef enum logic [1:0] {
        ITEM_STEP  = 2'd0,
        ITEM_WRITE = 2'd1,
        ITEM_READ  = 2'd2,
        ITEM_NONE  = 2'd3
    } item_op_t;

    localparam logic [7:0] OPC_HLT = 8'h00;
    localparam logic [7:0] OPC_LDA = 8'h01;
    localparam logic [7:0] OPC_LDB = 8'h02;
    localparam logic [7:0] OPC_CTA = 8'h03;
    localparam logic [7:0] OPC_STA = 8'h04;
    localparam logic [7:0] OPC_STB = 8'h05;
    localparam logic [7:0] OPC_ADD = 8'h06;
    localparam logic [7:0] OPC_SUB = 8'h07;
    localparam logic [7:0] OPC_AND = 8'h08;
    localparam logic [7:0] OPC_OR  = 8'h09;
    localparam logic [7:0] OPC_NOT = 8'h0A;
    localparam logic [7:0] OPC_XOR = 8'h0B;
    localparam logic [7:0] OPC_JE  = 8'h0C;
    localparam logic [7:0] OPC_JC  = 8'h0D;
    localparam logic [7:0] OPC_JZ  = 8'h0E;
    localparam logic [7:0] OPC_JMP = 8'h0F;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] address;
        logic [7:0] data;
    } in_item_t;

    typedef struct packed {
        logic [7:0] prog_counter;
        logic [7:0] acc_a;
        logic [7:0] acc_b;
        logic [7:0] result_c;
        logic [7:0] opcode_seen;
        logic       halted;
        logic       illegal;
        logic [7:0] read_data;
    } out_item_t;

    // one access per cycle to the byte memory
    typedef struct packed {
        logic       en;
        logic       we;
        logic [7:0] addr;
        logic [7:0] wdata;
    } mem_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OPC,
        ST_OPND,
        ST_LOAD,
        ST_RDATA,
        ST_DONE
    } state_t;

endpackage

### hdl/ebac_mem.sv
module ebac_mem #(
    parameter int MEM_DEPTH = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ebac_pkg::mem_req_t mem_req,
    output logic [7:0]        rdata
);
    import ebac_pkg::*;

    localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    logic [7:0]           mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] valid_reg;
    logic [7:0]           rd_raw_reg;
    logic                 hit_reg;
    logic                 in_range;
    logic [AW-1:0]        idx;

    assign in_range = ({1'b0, mem_req.addr} < 9'(MEM_DEPTH));
    assign idx      = mem_req.addr[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_req.en && mem_req.we && in_range)
        begin
            mem[idx] <= mem_req.wdata;
        end
        if (mem_req.en && !mem_req.we)
        begin
            rd_raw_reg <= mem[idx];
        end
    end

    // valid bits stand in for the cleared contents after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (mem_req.en && mem_req.we && in_range)
            begin
                valid_reg[idx] <= 1'b1;
            end
            if (mem_req.en && !mem_req.we)
            begin
                hit_reg <= in_range && valid_reg[idx];
            end
        end
    end

    assign rdata = hit_reg ? rd_raw_reg : 8'h00;

endmodule

### hdl/ebac_core.sv
module ebac_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  ebac_pkg::in_item_t  req,
    output logic                req_stall,
    output ebac_pkg::mem_req_t  mem_req,
    input  logic [7:0]          mem_rdata,
    input  logic                out_free,
    output logic                done,
    output ebac_pkg::out_item_t result
);
    import ebac_pkg::*;

    state_t     state_reg, state_next;
    logic [7:0] pc_reg, pc_next;
    logic [7:0] a_reg, a_next;
    logic [7:0] b_reg, b_next;
    logic [7:0] c_reg, c_next;
    logic [7:0] ir_reg, ir_next;
    logic       halt_reg, halt_next;
    logic       ill_reg, ill_next;
    logic [7:0] rd_reg, rd_next;
    logic       is_load;
    logic       take;

    assign is_load = (ir_reg == OPC_LDA) || (ir_reg == OPC_LDB);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    unique case (item_op_t'(req.op))
                        ITEM_STEP:  state_next = ST_OPC;
                        ITEM_READ:  state_next = ST_RDATA;
                        ITEM_WRITE: state_next = ST_DONE;
                        ITEM_NONE:  state_next = ST_DONE;
                    endcase
                end
            end
            ST_OPC:
            begin
                unique case (mem_rdata)
                    OPC_LDA, OPC_LDB, OPC_STA, OPC_STB,
                    OPC_JE, OPC_JC, OPC_JZ, OPC_JMP: state_next = ST_OPND;
                    default:                         state_next = ST_DONE;
                endcase
            end
            ST_OPND:  state_next = is_load ? ST_LOAD : ST_DONE;
            ST_LOAD:  state_next = ST_DONE;
            ST_RDATA: state_next = ST_DONE;
            ST_DONE:  state_next = out_free ? ST_IDLE : ST_DONE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        req_stall     = (state_reg != ST_IDLE);
        done          = (state_reg == ST_DONE) && out_free;
        mem_req       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    unique case (item_op_t'(req.op))
                        ITEM_STEP:
                        begin
                            mem_req.en   = 1'b1;
                            mem_req.addr = pc_reg;
                        end
                        ITEM_WRITE:
                        begin
                            mem_req.en    = 1'b1;
                            mem_req.we    = 1'b1;
                            mem_req.addr  = req.address;
                            mem_req.wdata = req.data;
                        end
                        ITEM_READ:
                        begin
                            mem_req.en   = 1'b1;
                            mem_req.addr = req.address;
                        end
                        ITEM_NONE:
                        begin
                            mem_req.en = 1'b0;
                        end
                    endcase
                end
            end
            ST_OPC:
            begin
                // operand fetch goes out before the opcode is decoded
                mem_req.en   = 1'b1;
                mem_req.addr = pc_reg + 8'd1;
            end
            ST_OPND:
            begin
                mem_req.addr = mem_rdata;
                if (is_load)
                begin
                    mem_req.en = 1'b1;
                end
                else if (ir_reg == OPC_STA)
                begin
                    mem_req.en    = 1'b1;
                    mem_req.we    = 1'b1;
                    mem_req.wdata = a_reg;
                end
                else if (ir_reg == OPC_STB)
                begin
                    mem_req.en    = 1'b1;
                    mem_req.we    = 1'b1;
                    mem_req.wdata = b_reg;
                end
            end
            default:
            begin
                mem_req.en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        pc_next   = pc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        c_next    = c_reg;
        ir_next   = ir_reg;
        halt_next = halt_reg;
        ill_next  = ill_reg;
        rd_next   = rd_reg;
        take      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    halt_next = 1'b0;
                    ill_next  = 1'b0;
                    rd_next   = 8'h00;
                end
            end
            ST_OPC:
            begin
                ir_next = mem_rdata;
                unique case (mem_rdata)
                    OPC_CTA:
                    begin
                        a_next  = c_reg;
                        pc_next = pc_reg + 8'd1;
                    end
                    OPC_ADD:
                    begin
                        c_next  = a_reg + b_reg;
                        pc_next = pc_reg + 8'd1;
                    end
                    OPC_SUB:
                    begin
                        c_next  = a_reg - b_reg;
                        pc_next = pc_reg + 8'd1;
                    end
                    OPC_AND:
                    begin
                        c_next  = a_reg & b_reg;
                        pc_next = pc_reg + 8'd1;
                    end
                    OPC_OR:
                    begin
                        c_next  = a_reg | b_reg;
                        pc_next = pc_reg + 8'd1;
                    end
                    OPC_NOT:
                    begin
                        c_next  = ~a_reg;
                        pc_next = pc_reg + 8'd1;
                    end
                    OPC_XOR:
                    begin
                        c_next  = a_reg ^ b_reg;
                        pc_next = pc_reg + 8'd1;
                    end
                    OPC_LDA, OPC_LDB, OPC_STA, OPC_STB,
                    OPC_JE, OPC_JC, OPC_JZ, OPC_JMP:
                    begin
                        pc_next = pc_reg;
                    end
                    default:
                    begin
                        // halt or any opcode above the jump group
                        halt_next = 1'b1;
                        ill_next  = (mem_rdata[7:4] != 4'h0);
                    end
                endcase
            end
            ST_OPND:
            begin
                unique case (ir_reg)
                    OPC_JE:  take = (a_reg == b_reg);
                    OPC_JC:  take = (b_reg >= a_reg);
                    OPC_JZ:  take = (a_reg == 8'h00);
                    OPC_JMP: take = 1'b1;
                    default: take = 1'b0;
                endcase
                pc_next = take ? mem_rdata : pc_reg + 8'd2;
            end
            ST_LOAD:
            begin
                if (ir_reg == OPC_LDA)
                begin
                    a_next = mem_rdata;
                end
                else
                begin
                    b_next = mem_rdata;
                end
            end
            ST_RDATA:
            begin
                rd_next = mem_rdata;
            end
            default:
            begin
                rd_next = rd_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pc_reg    <= 8'h00;
            a_reg     <= 8'h00;
            b_reg     <= 8'h00;
            c_reg     <= 8'h00;
            ir_reg    <= 8'h00;
            halt_reg  <= 1'b0;
            ill_reg   <= 1'b0;
            rd_reg    <= 8'h00;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            a_reg     <= a_next;
            b_reg     <= b_next;
            c_reg     <= c_next;
            ir_reg    <= ir_next;
            halt_reg  <= halt_next;
            ill_reg   <= ill_next;
            rd_reg    <= rd_next;
        end
    end

    assign result.prog_counter = pc_reg;
    assign result.acc_a        = a_reg;
    assign result.acc_b        = b_reg;
    assign result.result_c     = c_reg;
    assign result.opcode_seen  = ir_reg;
    assign result.halted       = halt_reg;
    assign result.illegal      = ill_reg;
    assign result.read_data    = rd_reg;

endmodule

### hdl/eight_bit_accumulator_cpu.sv
// Small accumulator CPU with a byte memory and registers A, B, C.
// Request channel (req_valid / req_stall / req): op selects a step (run one
// instruction at the program counter), a memory write or a memory read.
// Response channel (rsp_valid / rsp_stall / rsp): one beat per request with
// the registers after the request, the fetched opcode, the halt and illegal
// flags and, for reads, the byte read.
// Requests are handled one at a time through a single-port memory with a
// registered read; the core takes no new request until it is done with the
// last. States per request: write or unused op, straight to done; read,
// read data; halt/CTA/ALU step, opcode fetch; store or jump step, opcode
// fetch and operand fetch; load step, opcode fetch, operand fetch and load.
// Opcode fetch, operand fetch and the data access each make one access to
// the memory port and use its registered read data.
// The response sits in an output register; a new request is taken while it
// waits, and a finished request holds in its final state until the register
// is free. A stalled response holds.
// Reset clears the registers and marks every memory byte as zero at once;
// requests are taken from the first cycle after reset.
module eight_bit_accumulator_cpu #(
    parameter int MEM_DEPTH = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  ebac_pkg::in_item_t  req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output ebac_pkg::out_item_t rsp
);
    import ebac_pkg::*;

    mem_req_t   mem_req;
    logic [7:0] mem_rdata;
    logic       out_free;
    logic       done;
    out_item_t  result;
    out_item_t  rsp_reg;
    logic       rsp_valid_reg;

    assign out_free = !rsp_valid_reg || !rsp_stall;

    ebac_mem #(
        .MEM_DEPTH(MEM_DEPTH)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .mem_req (mem_req),
        .rdata   (mem_rdata)
    );

    ebac_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .req_stall (req_stall),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata),
        .out_free  (out_free),
        .done      (done),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (done)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            rsp_reg <= result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### hdl/ebac_checker.sv
module ebac_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_stall,
    input ebac_pkg::in_item_t  req,
    input logic                rsp_valid,
    input logic                rsp_stall,
    input ebac_pkg::out_item_t rsp
);
    import ebac_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled response beat changed");

    // one request at a time: a taken beat always blocks the next cycle
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while previous one in flight");

    a_illegal_halts: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.illegal |-> rsp.halted)
        else $error("illegal opcode without halt");

    a_halt_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.halted |-> (rsp.illegal == (rsp.opcode_seen != 8'h00)))
        else $error("halt flags disagree with fetched opcode");

    a_read_no_halt: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.read_data != 8'h00) |-> !rsp.halted && !rsp.illegal)
        else $error("read data on a step response");

endmodule

bind eight_bit_accumulator_cpu ebac_checker u_chk (.*);

### tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ebac_pkg::*;

    localparam int MEM_DEPTH  = 256;
    localparam int RAND_ITEMS = 900;
    localparam int TAIL_ITEMS = 120;
    localparam int MAX_CYCLES = 400000;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    in_item_t  req       = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    out_item_t rsp;

    eight_bit_accumulator_cpu #(
        .MEM_DEPTH(MEM_DEPTH)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp)
    );

    always #1 clk = ~clk;

    // shadow CPU state
    logic [7:0] cpu_mem [MEM_DEPTH];
    logic [7:0] cpu_pc = 8'h00;
    logic [7:0] cpu_a  = 8'h00;
    logic [7:0] cpu_b  = 8'h00;
    logic [7:0] cpu_c  = 8'h00;
    logic [7:0] cpu_ir = 8'h00;

    in_item_t  req_pending_q [$];
    out_item_t rsp_expected_q [$];

    int  n_pushed   = 0;
    int  n_accepted = 0;
    int  n_real     = 0;
    int  n_errors   = 0;
    int  cycles     = 0;
    int  src_gap    = 0;
    int  snk_gap    = 0;
    bit  req_taken  = 1'b0;
    bit  no_idle    = 1'b0;

    function automatic logic [7:0] mem_byte(logic [7:0] addr);
        if (int'(addr) < MEM_DEPTH)
            return cpu_mem[addr];
        return 8'h00;
    endfunction

    function automatic void mem_put(logic [7:0] addr, logic [7:0] val);
        if (int'(addr) < MEM_DEPTH)
            cpu_mem[addr] = val;
    endfunction

    function automatic out_item_t run_request(in_item_t it);
        out_item_t  r;
        logic [7:0] opc;
        logic [7:0] opnd;
        logic [7:0] rdata;
        logic       take;
        logic       halt;
        logic       bad;
        rdata = 8'h00;
        take  = 1'b0;
        halt  = 1'b0;
        bad   = 1'b0;
        case (item_op_t'(it.op))
            ITEM_STEP:
            begin
                opc    = mem_byte(cpu_pc);
                opnd   = mem_byte(cpu_pc + 8'd1);
                cpu_ir = opc;
                if (opc == OPC_HLT || opc > OPC_JMP)
                begin
                    halt = 1'b1;
                    bad  = (opc > OPC_JMP);
                end
                else
                begin
                    case (opc)
                        OPC_LDA: cpu_a = mem_byte(opnd);
                        OPC_LDB: cpu_b = mem_byte(opnd);
                        OPC_CTA: cpu_a = cpu_c;
                        OPC_STA: mem_put(opnd, cpu_a);
                        OPC_STB: mem_put(opnd, cpu_b);
                        OPC_ADD: cpu_c = cpu_a + cpu_b;
                        OPC_SUB: cpu_c = cpu_a - cpu_b;
                        OPC_AND: cpu_c = cpu_a & cpu_b;
                        OPC_OR:  cpu_c = cpu_a | cpu_b;
                        OPC_NOT: cpu_c = ~cpu_a;
                        OPC_XOR: cpu_c = cpu_a ^ cpu_b;
                        OPC_JE:  take = (cpu_a == cpu_b);
                        OPC_JC:  take = (cpu_b >= cpu_a);
                        OPC_JZ:  take = (cpu_a == 8'h00);
                        default: take = 1'b1;
                    endcase
                    if (opc >= OPC_JE)
                        cpu_pc = take ? opnd : cpu_pc + 8'd2;
                    else if (opc inside {OPC_LDA, OPC_LDB, OPC_STA, OPC_STB})
                        cpu_pc = cpu_pc + 8'd2;
                    else
                        cpu_pc = cpu_pc + 8'd1;
                end
            end
            ITEM_WRITE: mem_put(it.address, it.data);
            ITEM_READ:  rdata = mem_byte(it.address);
            default:    ;
        endcase
        r.prog_counter = cpu_pc;
        r.acc_a        = cpu_a;
        r.acc_b        = cpu_b;
        r.result_c     = cpu_c;
        r.opcode_seen  = cpu_ir;
        r.halted       = halt;
        r.illegal      = bad;
        r.read_data    = rdata;
        return r;
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            n_errors++;
        end
    endfunction

    // sample at the rising edge: predict on request beats, check response beats
    always @(posedge clk)
    begin
        out_item_t want;
        if (!rst_n)
            req_taken = 1'b0;
        else if (cycles >= MAX_CYCLES)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
        begin
            cycles++;
            req_taken = req_valid && !req_stall;
            if (req_taken)
            begin
                rsp_expected_q = {rsp_expected_q, run_request(req)};
                n_accepted++;
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (rsp_expected_q.size() == 0)
                begin
                    $error("response beat with no request outstanding");
                    n_errors++;
                end
                else
                begin
                    want = rsp_expected_q.pop_front();
                    check_field("prog_counter", want.prog_counter, rsp.prog_counter);
                    check_field("acc_a", want.acc_a, rsp.acc_a);
                    check_field("acc_b", want.acc_b, rsp.acc_b);
                    check_field("result_c", want.result_c, rsp.result_c);
                    check_field("opcode_seen", want.opcode_seen, rsp.opcode_seen);
                    check_field("halted", want.halted, rsp.halted);
                    check_field("illegal", want.illegal, rsp.illegal);
                    check_field("read_data", want.read_data, rsp.read_data);
                end
            end
        end
    end

    // drive at the falling edge
    always @(negedge clk)
    begin
        logic     nxt_valid;
        logic     nxt_stall;
        in_item_t nxt_req;
        nxt_valid = req_valid;
        nxt_req   = req;
        nxt_stall = 1'b0;
        if (rst_n)
        begin
            // a beat not yet taken holds
            if (!req_valid || req_taken)
            begin
                nxt_valid = 1'b0;
                if (src_gap > 0)
                    src_gap--;
                else if (!no_idle && $urandom_range(0, 5) == 0)
                    src_gap = $urandom_range(0, 6);
                else if (req_pending_q.size() != 0)
                begin
                    nxt_req   = req_pending_q.pop_front();
                    nxt_valid = 1'b1;
                end
            end
            if (snk_gap > 0)
            begin
                snk_gap--;
                nxt_stall = 1'b1;
            end
            else if (!no_idle && $urandom_range(0, 4) == 0)
            begin
                snk_gap   = $urandom_range(0, 6);
                nxt_stall = 1'b1;
            end
        end
        req_valid <= nxt_valid;
        req       <= nxt_req;
        rsp_stall <= nxt_stall;
    end

    task automatic push_item(item_op_t op, logic [7:0] addr, logic [7:0] dat);
        in_item_t it;
        it.op      = op;
        it.address = addr;
        it.data    = dat;
        req_pending_q = {req_pending_q, it};
        n_pushed++;
        if (op != ITEM_NONE)
            n_real++;
    endtask

    task automatic wait_drained();
        while (n_accepted != n_pushed || rsp_expected_q.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        logic [7:0] base;
        logic [7:0] p;
        logic [7:0] opc;
        logic [7:0] val;
        logic [7:0] data_addr [4];
        int         n_data;
        int         n_instr;
        int         start;
        int         kind;

        foreach (cpu_mem[i])
            cpu_mem[i] = 8'h00;

        // directed: field extremes, halt, illegal opcodes, wrap of pc and sums
        push_item(ITEM_WRITE, 8'hFF, 8'hFF);
        push_item(ITEM_READ,  8'hFF, 8'h00);
        push_item(ITEM_READ,  8'h00, 8'hFF);
        push_item(ITEM_NONE,  8'hFF, 8'hFF);
        push_item(ITEM_STEP,  8'h00, 8'h00);
        push_item(ITEM_WRITE, 8'h00, 8'hFF);
        push_item(ITEM_STEP,  8'hFF, 8'hFF);
        push_item(ITEM_WRITE, 8'h00, OPC_JMP + 8'd1);
        push_item(ITEM_STEP,  8'h00, 8'h00);
        push_item(ITEM_WRITE, 8'h00, OPC_JMP);
        push_item(ITEM_WRITE, 8'h01, 8'hFE);
        push_item(ITEM_STEP,  8'h00, 8'h00);
        push_item(ITEM_WRITE, 8'hFE, OPC_LDA);
        push_item(ITEM_STEP,  8'h00, 8'h00);
        push_item(ITEM_WRITE, 8'h00, OPC_NOT);
        push_item(ITEM_STEP,  8'h00, 8'h00);
        push_item(ITEM_WRITE, 8'h01, OPC_ADD);
        push_item(ITEM_STEP,  8'h00, 8'h00);
        push_item(ITEM_WRITE, 8'h02, OPC_LDB);
        push_item(ITEM_WRITE, 8'h03, 8'hFF);
        push_item(ITEM_STEP,  8'h00, 8'h00);
        push_item(ITEM_WRITE, 8'h04, OPC_ADD);
        push_item(ITEM_STEP,  8'h00, 8'h00);
        push_item(ITEM_WRITE, 8'h05, OPC_SUB);
        push_item(ITEM_STEP,  8'h00, 8'h00);

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        start = n_real;
        val   = 8'h00;
        while (n_real - start < RAND_ITEMS)
        begin
            // plan each program from the settled pc
            wait_drained();
            no_idle = (n_real - start >= RAND_ITEMS - TAIL_ITEMS);
            base    = cpu_pc;
            kind    = $urandom_range(0, 9);
            if (kind == 0)
            begin
                repeat ($urandom_range(3, 10))
                    push_item(item_op_t'($urandom_range(ITEM_STEP, ITEM_NONE)),
                              8'($urandom), 8'($urandom));
            end
            else
            begin
                n_data = $urandom_range(1, 4);
                for (int i = 0; i < n_data; i++)
                begin
                    data_addr[i] = 8'($urandom);
                    case ($urandom_range(0, 4))
                        0:       val = 8'h00;
                        1:       val = 8'hFF;
                        2:       val = val;
                        3:       val = 8'h80;
                        default: val = 8'($urandom);
                    endcase
                    push_item(ITEM_WRITE, data_addr[i], val);
                end
                n_instr = $urandom_range(1, 8);
                p       = base;
                for (int i = 0; i < n_instr; i++)
                begin
                    kind = $urandom_range(0, 99);
                    if (kind < 4)
                        opc = OPC_HLT;
                    else if (kind < 10)
                        opc = 8'($urandom);
                    else
                        opc = 8'($urandom_range(OPC_LDA, OPC_JMP));
                    push_item(ITEM_WRITE, p, opc);
                    p = p + 8'd1;
                    if (opc inside {OPC_LDA, OPC_LDB, OPC_STA, OPC_STB})
                    begin
                        if ($urandom_range(0, 3) != 0)
                            push_item(ITEM_WRITE, p, data_addr[$urandom_range(0, n_data - 1)]);
                        else
                            push_item(ITEM_WRITE, p, 8'($urandom));
                        p = p + 8'd1;
                    end
                    else if (opc >= OPC_JE && opc <= OPC_JMP)
                    begin
                        // jump targets mostly stay inside the program
                        if ($urandom_range(0, 4) != 0)
                            push_item(ITEM_WRITE, p, base + 8'($urandom_range(0, 2 * n_instr)));
                        else
                            push_item(ITEM_WRITE, p, 8'($urandom));
                        p = p + 8'd1;
                    end
                end
                repeat ($urandom_range(0, 2))
                    push_item(ITEM_READ, data_addr[$urandom_range(0, n_data - 1)], 8'($urandom));
                repeat (n_instr + $urandom_range(0, 3))
                begin
                    kind = $urandom_range(0, 19);
                    if (kind == 0)
                        push_item(ITEM_WRITE, 8'($urandom), 8'($urandom));
                    else if (kind == 1)
                        push_item(ITEM_READ, 8'($urandom), 8'($urandom));
                    else if (kind == 2)
                        push_item(ITEM_NONE, 8'($urandom), 8'($urandom));
                    push_item(ITEM_STEP, 8'($urandom), 8'($urandom));
                end
            end
        end

        wait_drained();
        repeat (20) @(negedge clk);
        if (n_errors == 0 && rsp_expected_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### eight_bit_accumulator_cpu.f
hdl/ebac_pkg.sv
hdl/ebac_mem.sv
hdl/ebac_core.sv
hdl/eight_bit_accumulator_cpu.sv
hdl/ebac_checker.sv
tb/tb.sv
